@@ hdl/psoc_pkg.sv @@
// ----------------------------------------------------------------------------
// psoc_pkg: shared types and constants for the obstacle clearance block
// Field widths of the item ports, the CORDIC arctangent table and the
// fixed angle constants used by the heading path.
// ----------------------------------------------------------------------------
package psoc_pkg;

    localparam int IN_W       = 24;
    localparam int TAG_W      = 8;
    localparam int HEADING_W  = 16;
    localparam int ALONG_W    = 26;
    localparam int CLEAR_W    = 25;
    localparam int ANGLE_W    = 32;
    localparam int CORDIC_MAX = 24;
    localparam int CW_MIN     = 8;
    localparam int CW_MAX     = 24;
    // The segment length is kept with six fraction bits.
    localparam int FRAC_BITS  = 6;
    // Squared length is scaled by 4096 before the root, giving those six bits.
    localparam int RAD_SHIFT  = 12;

    typedef logic signed [IN_W-1:0]      coord_t;
    typedef logic [TAG_W-1:0]            tag_t;
    typedef logic signed [HEADING_W-1:0] heading_t;
    typedef logic signed [ALONG_W-1:0]   along_t;
    typedef logic [CLEAR_W-1:0]          clear_t;
    typedef logic [ANGLE_W-1:0]          angle_t;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
    localparam angle_t ATAN_TURNS [CORDIC_MAX] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam angle_t QUARTER_TURN       = 32'h4000_0000;
    localparam angle_t THREE_QUARTER_TURN = 32'hC000_0000;
    localparam angle_t HEADING_ROUND      = 32'h0000_8000;

endpackage

@@ hdl/psoc_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// psoc_cordic_cell: one vectoring micro-rotation of the heading CORDIC
// Rotates the vector toward the x axis by atan(2^-SHIFT) and accumulates
// the angle; the result is registered for the next cell.
// ----------------------------------------------------------------------------
module psoc_cordic_cell #(
    parameter int XW    = 28,
    parameter int SHIFT = 0
) (
    input  logic                  clk,
    input  logic signed [XW-1:0]  x_in,
    input  logic signed [XW-1:0]  y_in,
    input  psoc_pkg::angle_t      ang_in,
    output logic signed [XW-1:0]  x_out,
    output logic signed [XW-1:0]  y_out,
    output psoc_pkg::angle_t      ang_out
);
    import psoc_pkg::*;

    localparam angle_t ATAN = ATAN_TURNS[SHIFT];

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 y_pos;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    angle_t               ang_next;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    angle_t               ang_reg;

    assign xs    = x_in >>> SHIFT;
    assign ys    = y_in >>> SHIFT;
    assign y_pos = !y_in[XW-1] && (y_in != '0);

    always_comb
    begin
        if (y_pos)
        begin
            x_next   = x_in + ys;
            y_next   = y_in - xs;
            ang_next = ang_in + ATAN;
        end
        else
        begin
            x_next   = x_in - ys;
            y_next   = y_in + xs;
            ang_next = ang_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = ang_reg;

endmodule

@@ hdl/psoc_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// psoc_sqrt_cell: one digit of the integer square root chain
// Brings down two radicand bits, tries the next root bit and passes the
// partial remainder, partial root and remaining radicand to the next cell.
// ----------------------------------------------------------------------------
module psoc_sqrt_cell #(
    parameter int ROOT_W = 31
) (
    input  logic                  clk,
    input  logic [ROOT_W:0]       rem_in,
    input  logic [ROOT_W-1:0]     root_in,
    input  logic [2*ROOT_W-1:0]   rad_in,
    output logic [ROOT_W:0]       rem_out,
    output logic [ROOT_W-1:0]     root_out,
    output logic [2*ROOT_W-1:0]   rad_out
);
    localparam int RAD_W = 2 * ROOT_W;

    logic [ROOT_W+2:0] cur;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              ge;
    logic [ROOT_W:0]   rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RAD_W-1:0]  rad_reg;

    assign cur   = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    // The remainder never exceeds twice the root, so it fits ROOT_W+1 bits.
    assign rem_next  = ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
    assign root_next = {root_in[ROOT_W-2:0], ge};

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= {rad_in[RAD_W-3:0], 2'b00};
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

@@ hdl/psoc_div_cell.sv @@
// ----------------------------------------------------------------------------
// psoc_div_cell: one quotient bit of the restoring divider chain
// Two lanes share one divisor. Each lane keeps its remainder and a word
// that holds the dividend bits still to come and the quotient bits so far.
// ----------------------------------------------------------------------------
module psoc_div_cell #(
    parameter int DEN_W = 31,
    parameter int LO_W  = 26
) (
    input  logic              clk,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [DEN_W-1:0]  rem_a_in,
    input  logic [LO_W-1:0]   lo_a_in,
    input  logic [DEN_W-1:0]  rem_b_in,
    input  logic [LO_W-1:0]   lo_b_in,
    output logic [DEN_W-1:0]  den_out,
    output logic [DEN_W-1:0]  rem_a_out,
    output logic [LO_W-1:0]   lo_a_out,
    output logic [DEN_W-1:0]  rem_b_out,
    output logic [LO_W-1:0]   lo_b_out
);
    function automatic logic [DEN_W+LO_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [LO_W-1:0]  lo,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] cur;
        logic [DEN_W:0] diff;
        logic           ge;
        cur  = {rem, lo[LO_W-1]};
        diff = cur - {1'b0, den};
        ge   = cur >= {1'b0, den};
        if (ge)
            return {diff[DEN_W-1:0], lo[LO_W-2:0], 1'b1};
        else
            return {cur[DEN_W-1:0], lo[LO_W-2:0], 1'b0};
    endfunction

    logic [DEN_W+LO_W-1:0] a_next;
    logic [DEN_W+LO_W-1:0] b_next;
    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W+LO_W-1:0] a_reg;
    logic [DEN_W+LO_W-1:0] b_reg;

    assign a_next = div_step(rem_a_in, lo_a_in, den_in);
    assign b_next = div_step(rem_b_in, lo_b_in, den_in);

    always_ff @(posedge clk)
    begin
        den_reg <= den_in;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign den_out   = den_reg;
    assign rem_a_out = a_reg[DEN_W+LO_W-1:LO_W];
    assign lo_a_out  = a_reg[LO_W-1:0];
    assign rem_b_out = b_reg[DEN_W+LO_W-1:LO_W];
    assign lo_b_out  = b_reg[LO_W-1:0];

endmodule

@@ hdl/path_segment_obstacle_clearance.sv @@
// ----------------------------------------------------------------------------
// path_segment_obstacle_clearance: heading, along distance and clearance
// For a path segment and an obstacle centre, reports the segment heading
// as a binary angle, the signed projection of the obstacle offset onto the
// segment direction, and the perpendicular distance to the segment line.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  ------------------------------------------
//  item in   start, busy          start_x, start_y, end_x, end_y,
//                                 obstacle_x, obstacle_y, obstacle_tag
//  result    done (one cycle)     heading_angle, along_distance, clearance,
//                                 result_tag
//
//  Every item gives exactly one result. W is the coordinate width clamped
//  to 8..24; the pipeline length is set by the square root chain of W + 7
//  cells and the divider chain of W + 2 cells, and the CORDIC runs beside
//  the root chain. A new item is taken in every cycle, so busy stays low.
//  Results leave in the order the items came in. Reset clears only the
//  valid pipeline.
//
//  Flow: the differences are formed, then the six products, then the dot
//  product, cross product and squared length. The squared length, scaled
//  by 4096, goes down a chain of root cells that give the length with six
//  fraction bits. The magnitudes of the dot and cross products, scaled by
//  64 and with half the length added for rounding, then go down a chain of
//  divider cells that share the length as divisor. The heading comes from
//  a CORDIC in vectoring mode after a quarter-turn pre-rotation for
//  vectors in the left half plane. A segment of zero length is turned into
//  a unit segment along +x at the product stage, which gives an along
//  distance equal to the x offset and a clearance equal to the magnitude
//  of the y offset; its heading is forced to zero.
// ----------------------------------------------------------------------------
module path_segment_obstacle_clearance #(
    parameter int COORD_WIDTH   = 24,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  psoc_pkg::coord_t    start_x,
    input  psoc_pkg::coord_t    start_y,
    input  psoc_pkg::coord_t    end_x,
    input  psoc_pkg::coord_t    end_y,
    input  psoc_pkg::coord_t    obstacle_x,
    input  psoc_pkg::coord_t    obstacle_y,
    input  psoc_pkg::tag_t      obstacle_tag,
    output logic                done,
    output psoc_pkg::heading_t  heading_angle,
    output psoc_pkg::along_t    along_distance,
    output psoc_pkg::clear_t    clearance,
    output psoc_pkg::tag_t      result_tag
);
    import psoc_pkg::*;

    // Effective coordinate width and CORDIC depth.
    localparam int CW  = (COORD_WIDTH < CW_MIN) ? CW_MIN :
                         ((COORD_WIDTH > CW_MAX) ? CW_MAX : COORD_WIDTH);
    localparam int NST = (CORDIC_STAGES < 1) ? 1 :
                         ((CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES);

    localparam int DW  = CW + 1;             // coordinate differences
    localparam int PW  = 2 * DW;             // products and their sums
    localparam int MW  = PW - 1;             // dot and cross magnitudes
    localparam int LW  = 2 * CW + 1;         // squared length
    localparam int SQ  = CW + 7;             // length with fraction bits
    localparam int RE  = 2 * SQ;             // radicand
    localparam int NW  = MW + FRAC_BITS + 1; // rounded dividend
    localparam int QW  = CW + 2;             // quotient
    localparam int XW  = DW + 3;             // CORDIC vector
    localparam int LAT = 5 + SQ + QW;        // accept to result
    localparam int TD  = 3 + SQ + QW;        // tag delay taps
    localparam int HD  = 2 + SQ + QW - NST;  // heading delay taps
    localparam int QX  = ((QW > ALONG_W) ? QW : ALONG_W) + 1;

    localparam logic [QX-1:0] ALONG_LIM = QX'(1) << (ALONG_W - 1);
    localparam logic [QX-1:0] CLEAR_LIM = QX'(1) << CLEAR_W;
    localparam along_t ALONG_MAX = {1'b0, {(ALONG_W-1){1'b1}}};
    localparam along_t ALONG_MIN = {1'b1, {(ALONG_W-1){1'b0}}};

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Valid pipeline: bit k marks an item in stage k + 1.
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    assign done = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // Stage 1: offsets of the end point and of the obstacle from the start.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] sx_c;
    logic signed [CW-1:0] sy_c;
    logic signed [CW-1:0] ex_c;
    logic signed [CW-1:0] ey_c;
    logic signed [CW-1:0] qx_c;
    logic signed [CW-1:0] qy_c;
    logic signed [DW-1:0] a_dx_next;
    logic signed [DW-1:0] a_dy_next;
    logic signed [DW-1:0] a_ox_next;
    logic signed [DW-1:0] a_oy_next;
    logic signed [DW-1:0] a_dx_reg;
    logic signed [DW-1:0] a_dy_reg;
    logic signed [DW-1:0] a_ox_reg;
    logic signed [DW-1:0] a_oy_reg;
    tag_t                 a_tag_reg;

    assign sx_c = start_x[CW-1:0];
    assign sy_c = start_y[CW-1:0];
    assign ex_c = end_x[CW-1:0];
    assign ey_c = end_y[CW-1:0];
    assign qx_c = obstacle_x[CW-1:0];
    assign qy_c = obstacle_y[CW-1:0];

    assign a_dx_next = DW'(ex_c) - DW'(sx_c);
    assign a_dy_next = DW'(ey_c) - DW'(sy_c);
    assign a_ox_next = DW'(qx_c) - DW'(sx_c);
    assign a_oy_next = DW'(qy_c) - DW'(sy_c);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_dx_reg  <= a_dx_next;
            a_dy_reg  <= a_dy_next;
            a_ox_reg  <= a_ox_next;
            a_oy_reg  <= a_oy_next;
            a_tag_reg <= obstacle_tag;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products, and the CORDIC quadrant pre-rotation.
    // ------------------------------------------------------------------
    logic                 zero_len;
    logic signed [PW-1:0] b_dx2_next;
    logic signed [PW-1:0] b_dy2_next;
    logic signed [PW-1:0] b_oxdx_next;
    logic signed [PW-1:0] b_oydy_next;
    logic signed [PW-1:0] b_oxdy_next;
    logic signed [PW-1:0] b_oydx_next;
    logic signed [PW-1:0] b_dx2_reg;
    logic signed [PW-1:0] b_dy2_reg;
    logic signed [PW-1:0] b_oxdx_reg;
    logic signed [PW-1:0] b_oydy_reg;
    logic signed [PW-1:0] b_oxdy_reg;
    logic signed [PW-1:0] b_oydx_reg;
    logic                 b_zero_reg;

    assign zero_len = (a_dx_reg == '0) && (a_dy_reg == '0);

    always_comb
    begin
        if (zero_len)
        begin
            // A unit segment along +x reproduces the zero-length answer.
            b_dx2_next  = PW'(1);
            b_dy2_next  = '0;
            b_oxdx_next = PW'(a_ox_reg);
            b_oydy_next = '0;
            b_oxdy_next = PW'(a_oy_reg);
            b_oydx_next = '0;
        end
        else
        begin
            b_dx2_next  = a_dx_reg * a_dx_reg;
            b_dy2_next  = a_dy_reg * a_dy_reg;
            b_oxdx_next = a_ox_reg * a_dx_reg;
            b_oydy_next = a_oy_reg * a_dy_reg;
            b_oxdy_next = a_ox_reg * a_dy_reg;
            b_oydx_next = a_oy_reg * a_dx_reg;
        end
    end

    logic signed [XW-1:0] pre_dx;
    logic signed [XW-1:0] pre_dy;
    logic signed [XW-1:0] pre_ndx;
    logic signed [XW-1:0] pre_ndy;
    logic signed [XW-1:0] pre_x_next;
    logic signed [XW-1:0] pre_y_next;
    angle_t               pre_ang_next;
    logic signed [XW-1:0] pre_x_reg;
    logic signed [XW-1:0] pre_y_reg;
    angle_t               pre_ang_reg;

    assign pre_dx  = XW'(a_dx_reg);
    assign pre_dy  = XW'(a_dy_reg);
    assign pre_ndx = -pre_dx;
    assign pre_ndy = -pre_dy;

    // Vectors in the left half plane are turned by a quarter turn first.
    always_comb
    begin
        if (!pre_dx[XW-1])
        begin
            pre_x_next   = pre_dx;
            pre_y_next   = pre_dy;
            pre_ang_next = '0;
        end
        else if (!pre_dy[XW-1])
        begin
            pre_x_next   = pre_dy;
            pre_y_next   = pre_ndx;
            pre_ang_next = QUARTER_TURN;
        end
        else
        begin
            pre_x_next   = pre_ndy;
            pre_y_next   = pre_dx;
            pre_ang_next = THREE_QUARTER_TURN;
        end
    end

    always_ff @(posedge clk)
    begin
        b_dx2_reg   <= b_dx2_next;
        b_dy2_reg   <= b_dy2_next;
        b_oxdx_reg  <= b_oxdx_next;
        b_oydy_reg  <= b_oydy_next;
        b_oxdy_reg  <= b_oxdy_next;
        b_oydx_reg  <= b_oydx_next;
        b_zero_reg  <= zero_len;
        pre_x_reg   <= pre_x_next;
        pre_y_reg   <= pre_y_next;
        pre_ang_reg <= pre_ang_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: dot product, cross product and squared length.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] c_dot_next;
    logic signed [PW-1:0] c_crs_next;
    logic signed [PW-1:0] l2_sum;
    logic signed [PW-1:0] c_dot_reg;
    logic signed [PW-1:0] c_crs_reg;
    logic [LW-1:0]        c_l2_reg;

    assign c_dot_next = b_oxdx_reg + b_oydy_reg;
    assign c_crs_next = b_oxdy_reg - b_oydx_reg;
    assign l2_sum     = b_dx2_reg + b_dy2_reg;

    always_ff @(posedge clk)
    begin
        c_dot_reg <= c_dot_next;
        c_crs_reg <= c_crs_next;
        c_l2_reg  <= l2_sum[LW-1:0];
    end

    // ------------------------------------------------------------------
    // Square root chain: length in six-fraction-bit fixed point.
    // ------------------------------------------------------------------
    logic [SQ:0]   sq_rem  [SQ+1];
    logic [SQ-1:0] sq_root [SQ+1];
    logic [RE-1:0] sq_rad  [SQ+1];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = {1'b0, c_l2_reg, {RAD_SHIFT{1'b0}}};

    genvar g;
    generate
        for (g = 0; g < SQ; g++)
        begin : g_sqrt
            psoc_sqrt_cell #(
                .ROOT_W (SQ)
            ) u_sqrt_cell (
                .clk      (clk),
                .rem_in   (sq_rem[g]),
                .root_in  (sq_root[g]),
                .rad_in   (sq_rad[g]),
                .rem_out  (sq_rem[g+1]),
                .root_out (sq_root[g+1]),
                .rad_out  (sq_rad[g+1])
            );
        end
    endgenerate

    // Dot and cross magnitudes ride beside the root chain.
    logic signed [PW-1:0] dot_neg_v;
    logic signed [PW-1:0] crs_neg_v;
    logic signed [PW-1:0] dot_abs;
    logic signed [PW-1:0] crs_abs;
    logic [MW-1:0]        ad_dot_reg [SQ];
    logic [MW-1:0]        ad_crs_reg [SQ];
    logic                 ad_neg_reg [SQ];

    assign dot_neg_v = -c_dot_reg;
    assign crs_neg_v = -c_crs_reg;
    assign dot_abs   = c_dot_reg[PW-1] ? dot_neg_v : c_dot_reg;
    assign crs_abs   = c_crs_reg[PW-1] ? crs_neg_v : c_crs_reg;

    always_ff @(posedge clk)
    begin
        ad_dot_reg[0] <= dot_abs[MW-1:0];
        ad_crs_reg[0] <= crs_abs[MW-1:0];
        ad_neg_reg[0] <= c_dot_reg[PW-1];
        for (int k = 1; k < SQ; k++)
        begin
            ad_dot_reg[k] <= ad_dot_reg[k-1];
            ad_crs_reg[k] <= ad_crs_reg[k-1];
            ad_neg_reg[k] <= ad_neg_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Dividend set-up: magnitude times 64 plus half the length.
    // ------------------------------------------------------------------
    logic [SQ-2:0] half_len;
    logic [NW-1:0] e_num_a_next;
    logic [NW-1:0] e_num_b_next;
    logic [NW-1:0] e_num_a_reg;
    logic [NW-1:0] e_num_b_reg;
    logic [SQ-1:0] e_den_reg;
    logic          e_neg_reg;

    assign half_len     = sq_root[SQ][SQ-1:1];
    assign e_num_a_next = NW'({ad_dot_reg[SQ-1], {FRAC_BITS{1'b0}}}) + NW'(half_len);
    assign e_num_b_next = NW'({ad_crs_reg[SQ-1], {FRAC_BITS{1'b0}}}) + NW'(half_len);

    always_ff @(posedge clk)
    begin
        e_num_a_reg <= e_num_a_next;
        e_num_b_reg <= e_num_b_next;
        e_den_reg   <= sq_root[SQ];
        e_neg_reg   <= ad_neg_reg[SQ-1];
    end

    // ------------------------------------------------------------------
    // Divider chain: one quotient bit per cell, two lanes, shared divisor.
    // The quotient is known to fit QW bits, so the upper dividend part
    // starts below the divisor.
    // ------------------------------------------------------------------
    logic [SQ-1:0] dv_den   [QW+1];
    logic [SQ-1:0] dv_rem_a [QW+1];
    logic [QW-1:0] dv_lo_a  [QW+1];
    logic [SQ-1:0] dv_rem_b [QW+1];
    logic [QW-1:0] dv_lo_b  [QW+1];

    assign dv_den[0]   = e_den_reg;
    assign dv_rem_a[0] = SQ'(e_num_a_reg[NW-1:QW]);
    assign dv_lo_a[0]  = e_num_a_reg[QW-1:0];
    assign dv_rem_b[0] = SQ'(e_num_b_reg[NW-1:QW]);
    assign dv_lo_b[0]  = e_num_b_reg[QW-1:0];

    generate
        for (g = 0; g < QW; g++)
        begin : g_div
            psoc_div_cell #(
                .DEN_W (SQ),
                .LO_W  (QW)
            ) u_div_cell (
                .clk       (clk),
                .den_in    (dv_den[g]),
                .rem_a_in  (dv_rem_a[g]),
                .lo_a_in   (dv_lo_a[g]),
                .rem_b_in  (dv_rem_b[g]),
                .lo_b_in   (dv_lo_b[g]),
                .den_out   (dv_den[g+1]),
                .rem_a_out (dv_rem_a[g+1]),
                .lo_a_out  (dv_lo_a[g+1]),
                .rem_b_out (dv_rem_b[g+1]),
                .lo_b_out  (dv_lo_b[g+1])
            );
        end
    endgenerate

    logic sg_reg [QW];

    always_ff @(posedge clk)
    begin
        sg_reg[0] <= e_neg_reg;
        for (int k = 1; k < QW; k++)
            sg_reg[k] <= sg_reg[k-1];
    end

    // ------------------------------------------------------------------
    // Heading CORDIC, then rounding to 16 bits and delay to the output.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cx   [NST+1];
    logic signed [XW-1:0] cy   [NST+1];
    angle_t               cang [NST+1];

    assign cx[0]   = pre_x_reg;
    assign cy[0]   = pre_y_reg;
    assign cang[0] = pre_ang_reg;

    generate
        for (g = 0; g < NST; g++)
        begin : g_cordic
            psoc_cordic_cell #(
                .XW    (XW),
                .SHIFT (g)
            ) u_cordic_cell (
                .clk     (clk),
                .x_in    (cx[g]),
                .y_in    (cy[g]),
                .ang_in  (cang[g]),
                .x_out   (cx[g+1]),
                .y_out   (cy[g+1]),
                .ang_out (cang[g+1])
            );
        end
    endgenerate

    logic     zd_reg [NST];
    angle_t   hd_sum;
    heading_t hd_next;
    heading_t hd_reg [HD];

    always_ff @(posedge clk)
    begin
        zd_reg[0] <= b_zero_reg;
        for (int k = 1; k < NST; k++)
            zd_reg[k] <= zd_reg[k-1];
    end

    assign hd_sum  = cang[NST] + HEADING_ROUND;
    assign hd_next = zd_reg[NST-1] ? '0 : hd_sum[ANGLE_W-1 -: HEADING_W];

    always_ff @(posedge clk)
    begin
        hd_reg[0] <= hd_next;
        for (int k = 1; k < HD; k++)
            hd_reg[k] <= hd_reg[k-1];
    end

    // Tag travels the whole pipeline.
    tag_t td_reg [TD];

    always_ff @(posedge clk)
    begin
        td_reg[0] <= a_tag_reg;
        for (int k = 1; k < TD; k++)
            td_reg[k] <= td_reg[k-1];
    end

    // ------------------------------------------------------------------
    // Output stage: sign, saturation and the result registers.
    // ------------------------------------------------------------------
    logic [QX-1:0] qa_ext;
    logic [QX-1:0] qb_ext;
    logic [QX-1:0] qa_neg;
    along_t        along_next;
    clear_t        clear_next;
    heading_t      heading_reg;
    along_t        along_reg;
    clear_t        clear_reg;
    tag_t          tag_reg;

    assign qa_ext = QX'(dv_lo_a[QW]);
    assign qb_ext = QX'(dv_lo_b[QW]);
    assign qa_neg = QX'(0) - qa_ext;

    always_comb
    begin
        if (sg_reg[QW-1])
            along_next = (qa_ext > ALONG_LIM) ? ALONG_MIN : qa_neg[ALONG_W-1:0];
        else
            along_next = (qa_ext >= ALONG_LIM) ? ALONG_MAX : qa_ext[ALONG_W-1:0];
        clear_next = (qb_ext >= CLEAR_LIM) ? {CLEAR_W{1'b1}} : qb_ext[CLEAR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        heading_reg <= hd_reg[HD-1];
        along_reg   <= along_next;
        clear_reg   <= clear_next;
        tag_reg     <= td_reg[TD-1];
    end

    assign heading_angle  = heading_reg;
    assign along_distance = along_reg;
    assign clearance      = clear_reg;
    assign result_tag     = tag_reg;

endmodule

@@ verif/clearance_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clearance_check: result predictor and comparator for the clearance block
// Watches the item and result channels, works out the heading, along
// distance and clearance of every accepted item and compares each result
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module clearance_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  psoc_pkg::coord_t   start_x,
    input  psoc_pkg::coord_t   start_y,
    input  psoc_pkg::coord_t   end_x,
    input  psoc_pkg::coord_t   end_y,
    input  psoc_pkg::coord_t   obstacle_x,
    input  psoc_pkg::coord_t   obstacle_y,
    input  psoc_pkg::tag_t     obstacle_tag,
    input  logic               done,
    input  psoc_pkg::heading_t heading_angle,
    input  psoc_pkg::along_t   along_distance,
    input  psoc_pkg::clear_t   clearance,
    input  psoc_pkg::tag_t     result_tag,
    output int                 mismatches,
    output int                 outstanding
);
    import psoc_pkg::*;

    localparam int     HEADING_STAGES = 16;
    localparam int     REPORT_LIMIT   = 10;
    // Far more entries than the pipeline can ever hold at once.
    localparam int     RING_DEPTH     = 1024;
    localparam longint ALONG_TOP      = (longint'(1) << (ALONG_W - 1)) - 1;
    localparam longint ALONG_BOTTOM   = -(longint'(1) << (ALONG_W - 1));
    localparam longint CLEAR_TOP      = (longint'(1) << CLEAR_W) - 1;
    localparam longint unsigned QUOT_CAP = 64'h0000_7FFF_FFFF_FFFF;

    typedef struct packed {
        heading_t heading;
        along_t   along;
        clear_t   clear;
        tag_t     tag;
    } clearance_result_t;

    // Predictions wait in a ring; the counts only ever grow.
    clearance_result_t expected_ring [RING_DEPTH];
    int                head_count;
    int                tail_count;
    int                fail_count;
    int                result_index;

    // Integer square root, rounded down.
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned probe;
        res   = 0;
        probe = 64'h1 << 62;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (n >= res + probe)
            begin
                n   = n - res - probe;
                res = (res >> 1) + probe;
            end
            else
            begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC; the angle is a fraction of a full turn.
    function automatic angle_t cordic_heading(longint vx, longint vy);
        angle_t acc;
        longint tmp;
        longint xs;
        longint ys;
        acc = '0;
        if (vx < 0)
        begin
            tmp = vx;
            if (vy >= 0)
            begin
                vx  = vy;
                vy  = -tmp;
                acc = QUARTER_TURN;
            end
            else
            begin
                vx  = -vy;
                vy  = tmp;
                acc = THREE_QUARTER_TURN;
            end
        end
        for (int i = 0; i < HEADING_STAGES; i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy > 0)
            begin
                vx  = vx + ys;
                vy  = vy - xs;
                acc = acc + ATAN_TURNS[i];
            end
            else
            begin
                vx  = vx - ys;
                vy  = vy + xs;
                acc = acc - ATAN_TURNS[i];
            end
        end
        return acc;
    endfunction

    // Division rounding to nearest, ties away from zero.
    function automatic longint round_quot(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        if (num < 0)
            mag = longint'(-num);
        else
            mag = num;
        q = (mag + den / 2) / den;
        if (q > QUOT_CAP)
            q = QUOT_CAP;
        if (num < 0)
            return -longint'(q);
        return longint'(q);
    endfunction

    function automatic clearance_result_t predict_clearance(
        coord_t sx, coord_t sy, coord_t ex, coord_t ey,
        coord_t qx, coord_t qy, tag_t tag
    );
        clearance_result_t r;
        longint            dx;
        longint            dy;
        longint            ox;
        longint            oy;
        longint            dot;
        longint            crs;
        longint            along;
        longint            clear;
        longint unsigned   lenq;
        angle_t            hd;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        ox = longint'(qx) - longint'(sx);
        oy = longint'(qy) - longint'(sy);
        hd = '0;
        if (dx == 0 && dy == 0)
        begin
            // Degenerate segment: direction taken as +x.
            along = ox;
            clear = (oy < 0) ? -oy : oy;
        end
        else
        begin
            lenq  = root_floor(longint'(dx * dx + dy * dy) << RAD_SHIFT);
            dot   = ox * dx + oy * dy;
            crs   = ox * dy - oy * dx;
            if (crs < 0)
                crs = -crs;
            along = round_quot(dot <<< FRAC_BITS, lenq);
            clear = round_quot(crs <<< FRAC_BITS, lenq);
            hd    = cordic_heading(dx, dy) + HEADING_ROUND;
        end
        if (along > ALONG_TOP)
            along = ALONG_TOP;
        if (along < ALONG_BOTTOM)
            along = ALONG_BOTTOM;
        if (clear > CLEAR_TOP)
            clear = CLEAR_TOP;
        r.heading = hd[ANGLE_W-1 -: HEADING_W];
        r.along   = along[ALONG_W-1:0];
        r.clear   = clear[CLEAR_W-1:0];
        r.tag     = tag;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch_channels
        clearance_result_t seen;
        clearance_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_ring[head_count % RING_DEPTH] = predict_clearance(start_x,
                    start_y, end_x, end_y, obstacle_x, obstacle_y, obstacle_tag);
                head_count++;
            end
            if (done)
            begin
                seen = '{heading_angle, along_distance, clearance, result_tag};
                if (head_count == tail_count)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("result %0d arrived with nothing expected", result_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_ring[tail_count % RING_DEPTH];
                    tail_count++;
                    if (seen !== want)
                    begin
                        if (fail_count < REPORT_LIMIT)
                        begin
                            $write("result %0d mismatch (expected/actual): heading %0d/%0d",
                                   result_index, want.heading, seen.heading);
                            $display(" along %0d/%0d clearance %0d/%0d tag %0d/%0d",
                                     want.along, seen.along, want.clear, seen.clear,
                                     want.tag, seen.tag);
                        end
                        fail_count++;
                    end
                end
                result_index++;
            end
            mismatches  <= fail_count;
            outstanding <= head_count - tail_count;
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for path_segment_obstacle_clearance
// Drives directed and random segment/obstacle queries with random gaps,
// lets clearance_check predict and compare every result, and reports the
// final verdict once all results have drained.
// ----------------------------------------------------------------------------
module tb;
    import psoc_pkg::*;

    // The drain wait and the idle limit are sized from the block's
    // pipeline length with plenty of margin.
    localparam int     DRAIN_CYCLES  = 80;
    localparam int     IDLE_LIMIT    = 2000;
    localparam int     RANDOM_ITEMS  = 1250;
    localparam int     MAX_GAP       = 13;
    localparam int     BURST_LEN     = 25;
    localparam coord_t C_MIN         = coord_t'(-(longint'(1) << (IN_W - 1)));
    localparam coord_t C_MAX         = coord_t'((longint'(1) << (IN_W - 1)) - 1);

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    coord_t   start_x;
    coord_t   start_y;
    coord_t   end_x;
    coord_t   end_y;
    coord_t   obstacle_x;
    coord_t   obstacle_y;
    tag_t     obstacle_tag;
    logic     done;
    heading_t heading_angle;
    along_t   along_distance;
    clear_t   clearance;
    tag_t     result_tag;
    int       mismatches;
    int       outstanding;
    int       idle_cycles = 0;
    // When clear, items go out back to back.
    bit       gaps_on;

    always #4 clk = ~clk;

    path_segment_obstacle_clearance dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .obstacle_x     (obstacle_x),
        .obstacle_y     (obstacle_y),
        .obstacle_tag   (obstacle_tag),
        .done           (done),
        .heading_angle  (heading_angle),
        .along_distance (along_distance),
        .clearance      (clearance),
        .result_tag     (result_tag)
    );

    clearance_check checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .obstacle_x     (obstacle_x),
        .obstacle_y     (obstacle_y),
        .obstacle_tag   (obstacle_tag),
        .done           (done),
        .heading_angle  (heading_angle),
        .along_distance (along_distance),
        .clearance      (clearance),
        .result_tag     (result_tag),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // Watchdog: any cycle that moves neither an item nor a result counts
    // toward the limit, so a hung pipeline ends the run.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // A coordinate within spread of centre, clipped to the port range.
    function automatic coord_t span_coord(longint centre, int spread);
        longint v;
        v = centre + longint'($urandom_range(0, 2 * spread)) - spread;
        if (v > longint'(C_MAX))
            v = C_MAX;
        if (v < longint'(C_MIN))
            v = C_MIN;
        return coord_t'(v);
    endfunction

    // A coordinate from the corners of the range, around zero, or anywhere.
    function automatic coord_t edge_coord();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return coord_t'(-1);
            4: return coord_t'(1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Present one query, hold it until the block takes it, then idle for a
    // random number of cycles when gaps are enabled. Always returns on a
    // rising edge so the next call can drive straight away.
    task automatic offer_query(input coord_t sx, input coord_t sy, input coord_t ex,
                               input coord_t ey, input coord_t qx, input coord_t qy,
                               input tag_t tag);
        int gap;
        start        <= 1'b1;
        start_x      <= sx;
        start_y      <= sy;
        end_x        <= ex;
        end_y        <= ey;
        obstacle_x   <= qx;
        obstacle_y   <= qy;
        obstacle_tag <= tag;
        do
            @(posedge clk);
        while (busy);
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every prediction has been answered.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t qx;
        coord_t qy;
        int     step;

        rst_n        = 1'b0;
        start        = 1'b0;
        start_x      = '0;
        start_y      = '0;
        end_x        = '0;
        end_y        = '0;
        obstacle_x   = '0;
        obstacle_y   = '0;
        obstacle_tag = '0;
        gaps_on      = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Zero-length segments take +x as the direction.
        offer_query('0, '0, '0, '0, '0, '0, 8'd0);
        offer_query(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 8'd255);
        offer_query(-5, 7, -5, 7, 1000, -3000, 8'h5A);
        // Axis-aligned headings, then segments near -x and a short diagonal;
        // the -x direction reports the angle of pi as the most negative code.
        offer_query('0, '0, 1000, '0, 500, -300, 8'd1);
        offer_query('0, '0, -1000, '0, 500, -300, 8'd2);
        offer_query('0, '0, '0, 1000, -40, 2000, 8'd3);
        offer_query('0, '0, '0, -1000, 40, 2000, 8'd4);
        offer_query('0, '0, -1000, 1, 10, 10, 8'd5);
        offer_query('0, '0, -1000, -1, 10, 10, 8'd6);
        offer_query('0, '0, -1, -1, 3, -7, 8'd7);
        offer_query('0, '0, 1, '0, C_MAX, C_MIN, 8'd8);
        offer_query('0, '0, '0, -1, C_MIN, C_MAX, 8'd9);
        // Full-range diagonals in all four quadrants, then full-range axis segments.
        offer_query(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, 8'hA5);
        offer_query(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, 8'h0F);
        offer_query(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, 8'hF0);
        offer_query(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, 8'h80);
        offer_query(C_MIN, '0, C_MAX, '0, C_MIN, C_MAX, 8'h7F);
        offer_query('0, C_MIN, '0, C_MAX, C_MAX, C_MIN, 8'h3C);
        offer_query(C_MAX, '0, C_MIN, '0, C_MIN, C_MIN, 8'hC3);
        // Obstacle behind the start, exactly on the line, and 3-4-5 cases.
        offer_query(100, 100, 200, 200, -500, -400, 8'd10);
        offer_query(10, 20, 40, 60, 70, 100, 8'd11);
        offer_query('0, '0, 3, 4, 1, '0, 8'd12);
        offer_query(-7, 9, -4, 5, -20, -20, 8'd13);

        // Let the pipeline empty completely once before random traffic.
        drain_results();

        for (step = 0; step < RANDOM_ITEMS; step++)
        begin
            if (step % BURST_LEN == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (step == RANDOM_ITEMS / 2)
                drain_results();
            case ($urandom_range(0, 9)) inside
                [0:3]:
                begin
                    sx = coord_t'($urandom);
                    sy = coord_t'($urandom);
                    ex = coord_t'($urandom);
                    ey = coord_t'($urandom);
                    qx = coord_t'($urandom);
                    qy = coord_t'($urandom);
                end
                [4:5]:
                begin
                    // Short segment with a nearby obstacle.
                    sx = span_coord(0, 1 << 22);
                    sy = span_coord(0, 1 << 22);
                    ex = span_coord(sx, 64);
                    ey = span_coord(sy, 64);
                    qx = span_coord(sx, 1 << 16);
                    qy = span_coord(sy, 1 << 16);
                end
                [6:7]:
                begin
                    // Obstacle close to the line through the segment.
                    sx = span_coord(0, 1 << 22);
                    sy = span_coord(0, 1 << 22);
                    ex = span_coord(0, 1 << 22);
                    ey = span_coord(0, 1 << 22);
                    qx = span_coord(longint'(sx) + (longint'(ex) - longint'(sx)) *
                                    longint'($urandom_range(0, 32)) / 16 -
                                    (longint'(ex) - longint'(sx)) / 2, 8);
                    qy = span_coord(longint'(sy) + (longint'(qx) - longint'(sx)) *
                                    (longint'(ey) - longint'(sy)) /
                                    ((longint'(ex) == longint'(sx)) ? 1 :
                                     (longint'(ex) - longint'(sx))), 8);
                end
                8:
                begin
                    // Degenerate and axis-aligned segments.
                    sx = span_coord(0, 1 << 22);
                    sy = span_coord(0, 1 << 22);
                    qx = coord_t'($urandom);
                    qy = coord_t'($urandom);
                    ex = span_coord(sx, 1 << 20);
                    ey = span_coord(sy, 1 << 20);
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            ex = sx;
                            ey = sy;
                        end
                        1: ex = sx;
                        2: ey = sy;
                        default:
                        begin
                            ex = span_coord(longint'(sx) - (1 << 20), (1 << 20) - 1);
                            ey = sy;
                        end
                    endcase
                end
                default:
                begin
                    sx = edge_coord();
                    sy = edge_coord();
                    ex = edge_coord();
                    ey = edge_coord();
                    qx = edge_coord();
                    qy = edge_coord();
                end
            endcase
            offer_query(sx, sy, ex, ey, qx, qy, tag_t'($urandom));
        end

        // Wait out the pipeline, then give stray results time to show up.
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ path_segment_obstacle_clearance.f @@
hdl/psoc_pkg.sv
hdl/psoc_cordic_cell.sv
hdl/psoc_sqrt_cell.sv
hdl/psoc_div_cell.sv
hdl/path_segment_obstacle_clearance.sv
verif/clearance_check.sv
verif/tb.sv
